// File: sv/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// Each macro expands to one labeled concurrent assertion clocked on a rising edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every edge outside reset.
`define ASSERT_ALWAYS(lbl, clk_s, rstn_s, expr, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (expr)) \
		else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/fbpa_pkg.sv
// Shared types and constants of the fixed block pool allocator.
// Used by the controller, the datapath, the divider and the top level.
package fbpa_pkg;

	localparam int ADDR_W     = 32;
	localparam int SIZE_W     = 17;
	localparam int BCNT_W     = 9;
	localparam int CFG_W      = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int STATUS_W   = 3;
	localparam int IN_TDATA_W = 32;
	localparam int OUT_FLD_W  = STATUS_W + ADDR_W + 2 * BCNT_W;
	localparam int OUT_TDATA_W = ((OUT_FLD_W + 7) / 8) * 8;
	localparam int OUT_PAD_W  = OUT_TDATA_W - OUT_FLD_W;

	localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd2;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_NULL     = 3'd2,
		ST_RANGE    = 3'd3,
		ST_MISALIGN = 3'd4,
		ST_NOT_USED = 3'd5
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic    take_in;
		logic    stack_rd;
		logic    mul_alloc;
		logic    mul_range;
		logic    div_start;
		logic    map_rd;
		logic    commit_pop;
		logic    commit_push;
		logic    load_out;
		status_t status;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic top_zero;
		logic addr_null;
		logic out_range;
		logic div_done;
		logic misaligned;
		logic in_use;
	} dp_stat_t;

endpackage

// File: sv/fbpa_div.sv
// Radix-2 restoring divider: one quotient bit per cycle.
// Depends on fbpa_pkg for the address and block size widths.
module fbpa_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [fbpa_pkg::ADDR_W-1:0] dividend,
	input  logic [fbpa_pkg::SIZE_W-1:0] divisor,
	output logic                        done,
	output logic [fbpa_pkg::ADDR_W-1:0] quotient,
	output logic [fbpa_pkg::SIZE_W-1:0] remainder
);
	import fbpa_pkg::*;

	localparam int CNT_W = $clog2(ADDR_W + 1);

	logic [SIZE_W-1:0] rem_q;
	logic [ADDR_W-1:0] quo_q;
	logic [SIZE_W-1:0] dvs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [SIZE_W:0]   shifted;
	logic [SIZE_W:0]   diff;
	logic              fits;

	assign shifted = {rem_q, quo_q[ADDR_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign fits    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ADDR_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[SIZE_W-1:0] : shifted[SIZE_W-1:0];
			quo_q <= {quo_q[ADDR_W-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// File: sv/fbpa_dp.sv
// Allocator datapath: configuration registers, free stack and in-use map memories,
// counters, multiplier, range check and output register. Uses fbpa_pkg and fbpa_div.
`include "assert_macros.svh"
module fbpa_dp #(
	parameter int MAX_BLOCKS = 256,
	parameter int ADDR_BITS  = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fbpa_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic [fbpa_pkg::ADDR_W-1:0]    in_addr,
	input  fbpa_pkg::dp_cmd_t              cmd,
	output fbpa_pkg::dp_stat_t             stat,
	output logic [fbpa_pkg::STATUS_W-1:0]  out_status,
	output logic [fbpa_pkg::ADDR_W-1:0]    out_address,
	output logic [fbpa_pkg::BCNT_W-1:0]    out_free,
	output logic [fbpa_pkg::BCNT_W-1:0]    out_used
);
	import fbpa_pkg::*;

	localparam int IW   = $clog2(MAX_BLOCKS);
	localparam int CW   = $clog2(MAX_BLOCKS + 1);
	localparam int PW   = CW + SIZE_W;
	localparam int CMPW = (PW > ADDR_W) ? PW : ADDR_W;
	localparam int SUMW = CMPW + 1;
	localparam logic [63:0] AMASK = (ADDR_BITS >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF :
		((64'd1 << ADDR_BITS) - 64'd1);

	function automatic logic [CW-1:0] eff_count(input logic [BCNT_W-1:0] bc);
		if (bc == '0)
			eff_count = CW'(1);
		else if (32'(bc) > 32'(MAX_BLOCKS))
			eff_count = CW'(MAX_BLOCKS);
		else
			eff_count = CW'(bc);
	endfunction

	logic [ADDR_W-1:0] base_q;
	logic [SIZE_W-1:0] size_q;
	logic [BCNT_W-1:0] bcnt_q;
	logic [SIZE_W-1:0] size_eff;
	logic [CW-1:0]     cnt_eff;

	logic [CW-1:0]     top_q;
	logic [CW-1:0]     low_q;
	logic [CW-1:0]     alloc_q;
	logic [CW-1:0]     top_nx;
	logic [CW-1:0]     alloc_nx;
	logic [CW-1:0]     pos_c;

	logic [IW-1:0]     stack_mem [MAX_BLOCKS];
	logic              map_mem [MAX_BLOCKS];
	logic [IW-1:0]     stk_rd_q;
	logic              map_rd_q;

	logic [ADDR_W-1:0] addr_q;
	logic [IW-1:0]     idx_q;
	logic [IW-1:0]     idx_alloc;
	logic [IW-1:0]     div_idx;
	logic [CW-1:0]     mul_a;
	logic [PW-1:0]     prod_q;
	logic [ADDR_W-1:0] offset;
	logic [SUMW-1:0]   addr_sum;
	logic [ADDR_W-1:0] addr_calc;

	logic              div_done;
	logic [ADDR_W-1:0] div_quo;
	logic [SIZE_W-1:0] div_rem;

	logic [STATUS_W-1:0] out_status_q;
	logic [ADDR_W-1:0]   out_addr_q;
	logic [BCNT_W-1:0]   out_free_q;
	logic [BCNT_W-1:0]   out_used_q;
	logic [CW:0]         bal_sum;

	assign size_eff = (size_q == '0) ? SIZE_W'(1) : size_q;
	assign cnt_eff  = eff_count(bcnt_q);

	// Configuration; a block count write re-initializes the pool counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= ADDR_W'(4096);
			size_q <= SIZE_W'(64);
			bcnt_q <= BCNT_W'(256);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_POOL_BASE:   base_q <= cfg_wdata[ADDR_W-1:0];
				CFG_BLOCK_SIZE:  size_q <= cfg_wdata[SIZE_W-1:0];
				CFG_BLOCK_COUNT: bcnt_q <= cfg_wdata[BCNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		top_nx   = top_q;
		alloc_nx = alloc_q;
		if (cmd.commit_pop) begin
			top_nx   = top_q - CW'(1);
			alloc_nx = alloc_q + CW'(1);
		end else if (cmd.commit_push) begin
			if (top_q < CW'(MAX_BLOCKS))
				top_nx = top_q + CW'(1);
			if (alloc_q != '0)
				alloc_nx = alloc_q - CW'(1);
		end
	end

	// low_q is the lowest stack top since init. Stack slots and map bits at or
	// above it have been written; below it they still hold their init values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q   <= eff_count(BCNT_W'(256));
			low_q   <= eff_count(BCNT_W'(256));
			alloc_q <= '0;
		end else if (cfg_we && cfg_index == CFG_BLOCK_COUNT) begin
			top_q   <= eff_count(cfg_wdata[BCNT_W-1:0]);
			low_q   <= eff_count(cfg_wdata[BCNT_W-1:0]);
			alloc_q <= '0;
		end else begin
			top_q   <= top_nx;
			alloc_q <= alloc_nx;
			if (cmd.commit_pop && top_nx < low_q)
				low_q <= top_nx;
		end
	end

	assign pos_c = top_q - CW'(1);

	always_ff @(posedge clk) begin
		if (cmd.commit_push && top_q < CW'(MAX_BLOCKS))
			stack_mem[IW'(top_q)] <= idx_q;
		if (cmd.stack_rd)
			stk_rd_q <= stack_mem[IW'(pos_c)];
	end

	assign div_idx = div_quo[IW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.commit_pop || cmd.commit_push)
			map_mem[idx_q] <= cmd.commit_pop;
		if (cmd.map_rd)
			map_rd_q <= map_mem[div_idx];
	end

	assign idx_alloc = (pos_c < low_q) ? IW'(pos_c) : stk_rd_q;
	assign mul_a     = cmd.mul_alloc ? CW'(idx_alloc) : cnt_eff;

	always_ff @(posedge clk) begin
		if (cmd.take_in)
			addr_q <= in_addr;
		if (cmd.mul_alloc || cmd.mul_range)
			prod_q <= PW'(mul_a) * PW'(size_eff);
		if (cmd.mul_alloc)
			idx_q <= idx_alloc;
		else if (cmd.map_rd)
			idx_q <= div_idx;
	end

	assign offset = addr_q - base_q;

	fbpa_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (offset),
		.divisor   (size_eff),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_comb begin
		stat.top_zero   = top_q == '0;
		stat.addr_null  = addr_q == '0;
		stat.out_range  = (addr_q < base_q) || (CMPW'(offset) >= CMPW'(prod_q));
		stat.div_done   = div_done;
		stat.misaligned = div_rem != '0;
		stat.in_use     = map_rd_q && (CW'(idx_q) >= low_q);
	end

	assign addr_sum  = SUMW'(base_q) + SUMW'(prod_q);
	assign addr_calc = addr_sum[ADDR_W-1:0] & AMASK[ADDR_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status_q <= cmd.status;
			out_addr_q   <= cmd.commit_pop ? addr_calc : '0;
			out_free_q   <= BCNT_W'(top_nx);
			out_used_q   <= BCNT_W'(alloc_nx);
		end
	end

	assign out_status  = out_status_q;
	assign out_address = out_addr_q;
	assign out_free    = out_free_q;
	assign out_used    = out_used_q;

	assign bal_sum = (CW + 1)'(top_q) + (CW + 1)'(alloc_q);

	`ASSERT_ALWAYS(a_count_balance, clk, arst_n, bal_sum == (CW + 1)'(cnt_eff), "free plus used differs from block count")
	`ASSERT_ALWAYS(a_low_water, clk, arst_n, low_q <= top_q, "low-water mark above stack top")

endmodule

// File: sv/fbpa_ctrl.sv
// Allocator controller: sequences allocate and free requests over the datapath
// and owns the input and output handshakes. Uses fbpa_pkg.
`include "assert_macros.svh"
module fbpa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic               opcode,
	output logic               m_tvalid,
	input  logic               m_tready,
	output fbpa_pkg::dp_cmd_t  cmd,
	input  fbpa_pkg::dp_stat_t stat
);
	import fbpa_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE      = 8'b0000_0001,
		S_ALLOC_RD  = 8'b0000_0010,
		S_ALLOC_MUL = 8'b0000_0100,
		S_FREE_MUL  = 8'b0000_1000,
		S_FREE_CHK  = 8'b0001_0000,
		S_FREE_DIV  = 8'b0010_0000,
		S_FREE_MAP  = 8'b0100_0000,
		S_FIN       = 8'b1000_0000
	} state_t;

	state_t  state_q, state_d;
	status_t status_q, status_d;
	logic    op_q;
	logic    m_tvalid_q;

	always_comb begin
		state_d    = state_q;
		status_d   = status_q;
		cmd        = '0;
		cmd.status = status_q;
		s_tready   = state_q == S_IDLE;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.take_in = 1'b1;
					state_d = (opcode == OP_FREE) ? S_FREE_MUL : S_ALLOC_RD;
				end
			end
			S_ALLOC_RD: begin
				if (stat.top_zero) begin
					status_d = ST_EMPTY;
					state_d  = S_FIN;
				end else begin
					cmd.stack_rd = 1'b1;
					state_d      = S_ALLOC_MUL;
				end
			end
			S_ALLOC_MUL: begin
				cmd.mul_alloc = 1'b1;
				status_d      = ST_OK;
				state_d       = S_FIN;
			end
			S_FREE_MUL: begin
				cmd.mul_range = 1'b1;
				state_d       = S_FREE_CHK;
			end
			S_FREE_CHK: begin
				if (stat.addr_null) begin
					status_d = ST_NULL;
					state_d  = S_FIN;
				end else if (stat.out_range) begin
					status_d = ST_RANGE;
					state_d  = S_FIN;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_FREE_DIV;
				end
			end
			S_FREE_DIV: begin
				if (stat.div_done) begin
					if (stat.misaligned) begin
						status_d = ST_MISALIGN;
						state_d  = S_FIN;
					end else begin
						cmd.map_rd = 1'b1;
						state_d    = S_FREE_MAP;
					end
				end
			end
			S_FREE_MAP: begin
				status_d = stat.in_use ? ST_OK : ST_NOT_USED;
				state_d  = S_FIN;
			end
			S_FIN: begin
				// hold until the output register is free, then commit and load
				if (!m_tvalid_q || m_tready) begin
					cmd.load_out    = 1'b1;
					cmd.commit_pop  = (status_q == ST_OK) && (op_q == OP_ALLOC);
					cmd.commit_push = (status_q == ST_OK) && (op_q == OP_FREE);
					state_d         = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			status_q   <= ST_OK;
			op_q       <= OP_ALLOC;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
			if (cmd.take_in)
				op_q <= opcode;
			if (cmd.load_out)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;

	`ASSERT_NEXT(a_one_in_flight, clk, arst_n, s_tvalid && s_tready, !s_tready, "new transfer taken while a request is in progress")

endmodule

// File: sv/fixed_block_pool_allocator_unit.sv
// Fixed block pool allocator: top level joining controller and datapath.
// Depends on fbpa_pkg, fbpa_ctrl, fbpa_dp and fbpa_div.
//
// Usage:
//   Input stream: s_tuser carries the opcode (0 allocate, 1 free), s_tdata the
//   byte address to free. One request is taken at a time; a transfer happens
//   when s_tvalid and s_tready are both high.
//   Output stream: one result per request in m_tdata (status, block address,
//   free and used counts), held in an output register until m_tready.
//   Sequencing: an allocate reads the free stack and forms the block address;
//   on an empty pool it skips both. A free forms the pool span and checks
//   null and range, then runs the 32-step radix-2 divider that forms
//   offset / block_size and, if aligned, reads the in-use map.
//   While the receiver stalls, a finished request waits in its last state and
//   commits only when the output register frees up; the controller then returns
//   to idle and takes the next request.
//   Configuration writes (cfg_we, cfg_index, cfg_wdata) are registered and
//   must be issued while idle. Writing block_count re-initializes the pool in
//   that same cycle: no clearing pass, a low-water mark marks stale entries.
//   Reset: pool_base 4096, block_size 64, block_count 256, all blocks free.
module fixed_block_pool_allocator_unit #(
	parameter int MAX_BLOCKS = 256,
	parameter int ADDR_BITS  = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [fbpa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fbpa_pkg::CFG_W-1:0]       cfg_wdata,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [fbpa_pkg::IN_TDATA_W-1:0]  s_tdata,   // free_address[31:0]
	input  logic                             s_tuser,   // opcode
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// status[2:0], block_address[34:3], free_blocks[43:35], used_blocks[52:44], zero pad
	output logic [fbpa_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import fbpa_pkg::*;

	dp_cmd_t             cmd;
	dp_stat_t            stat;
	logic [STATUS_W-1:0] out_status;
	logic [ADDR_W-1:0]   out_address;
	logic [BCNT_W-1:0]   out_free;
	logic [BCNT_W-1:0]   out_used;

	fbpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.opcode   (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	fbpa_dp #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.ADDR_BITS  (ADDR_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_addr     (s_tdata[ADDR_W-1:0]),
		.cmd         (cmd),
		.stat        (stat),
		.out_status  (out_status),
		.out_address (out_address),
		.out_free    (out_free),
		.out_used    (out_used)
	);

	assign m_tdata = {{OUT_PAD_W{1'b0}}, out_used, out_free, out_address, out_status};

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the fixed block pool allocator: a table of directed requests,
// then random allocate/free traffic across many pool settings and handshake idling mixes.
// Depends on fbpa_pkg and fixed_block_pool_allocator_unit.
module tb;
	import fbpa_pkg::*;

	localparam int POOL_MAX     = 256;
	localparam int HOLD_CYCLES  = 400;
	localparam int QUIET_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 50;

	typedef struct packed {
		status_t     status;
		logic [31:0] block_addr;
		logic [8:0]  free_cnt;
		logic [8:0]  used_cnt;
	} pool_reply_t;

	typedef enum logic [1:0] {
		ROW_REQ,
		ROW_KNOWN,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t              kind;
		logic                   op;
		logic [CFG_IDX_W-1:0]   reg_idx;
		logic [31:0]            value;   // free address or register data
		pool_reply_t            want;
	} dir_row_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_W-1:0]       cfg_wdata = '0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;   // free_address[31:0]
	logic                   s_tuser   = 1'b0; // opcode
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	// status[2:0], block_address[34:3], free_blocks[43:35], used_blocks[52:44], zero pad
	logic [OUT_TDATA_W-1:0] m_tdata;

	// mirror of the pool
	logic [31:0]  cfg_base;
	logic [16:0]  cfg_size;
	logic [8:0]   cfg_count;
	logic [7:0]   mdl_stack [POOL_MAX];
	logic [255:0] mdl_busy;
	logic [8:0]   mdl_top;
	logic [8:0]   mdl_used;

	pool_reply_t reply_q [$];
	dir_row_t    dir_tab [$];

	int errors      = 0;
	int n_sent      = 0;
	int n_settings  = 0;
	int idle_pct    = 0;
	int stall_pct   = 0;
	int hold_reqs   = 0;
	int hold_seen   = 0;
	int hold_left   = 0;
	int quiet       = 0;
	int seen_status [6] = '{default: 0};

	fixed_block_pool_allocator_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int pool_blocks();
		if (cfg_count == 0)
			return 1;
		if (cfg_count > POOL_MAX)
			return POOL_MAX;
		return int'(cfg_count);
	endfunction

	function automatic int unsigned pool_size();
		return (cfg_size == 0) ? 1 : int'(cfg_size);
	endfunction

	function automatic logic [31:0] block_addr_of(input int idx);
		return 32'(64'(cfg_base) + 64'(idx) * 64'(pool_size()));
	endfunction

	function automatic void pool_clear();
		for (int i = 0; i < POOL_MAX; i++)
			mdl_stack[i] = 8'(i);
		mdl_busy = '0;
		mdl_top  = 9'(pool_blocks());
		mdl_used = '0;
	endfunction

	// Work out the reply to one request and advance the mirrored pool.
	function automatic pool_reply_t predict_pool_reply(input logic op, input logic [31:0] addr);
		pool_reply_t r;
		logic [63:0] size, span, offset, blk;
		logic [7:0]  idx;
		r.status     = ST_OK;
		r.block_addr = '0;
		size = 64'(pool_size());
		span = size * 64'(pool_blocks());
		if (op == OP_ALLOC) begin
			if (mdl_top == 0) begin
				r.status = ST_EMPTY;
			end else begin
				mdl_top = mdl_top - 9'd1;
				idx = mdl_stack[mdl_top[7:0]];
				mdl_busy[idx] = 1'b1;
				mdl_used = mdl_used + 9'd1;
				r.block_addr = 32'(64'(cfg_base) + 64'(idx) * size);
			end
		end else if (addr == 0) begin
			r.status = ST_NULL;
		end else if (64'(addr) < 64'(cfg_base) || 64'(addr) - 64'(cfg_base) >= span) begin
			r.status = ST_RANGE;
		end else begin
			offset = 64'(addr) - 64'(cfg_base);
			blk = offset / size;
			if (offset % size != 0) begin
				r.status = ST_MISALIGN;
			end else if (blk >= POOL_MAX || !mdl_busy[blk[7:0]]) begin
				r.status = ST_NOT_USED;
			end else begin
				mdl_busy[blk[7:0]] = 1'b0;
				if (mdl_used > 0)
					mdl_used = mdl_used - 9'd1;
				if (mdl_top < POOL_MAX) begin
					mdl_stack[mdl_top[7:0]] = blk[7:0];
					mdl_top = mdl_top + 9'd1;
				end
			end
		end
		r.free_cnt = mdl_top;
		r.used_cnt = mdl_used;
		return r;
	endfunction

	function automatic dir_row_t row_req(input logic op, input logic [31:0] addr);
		dir_row_t r;
		r = '0;
		r.kind  = ROW_REQ;
		r.op    = op;
		r.value = addr;
		return r;
	endfunction

	function automatic dir_row_t row_known(input logic op, input logic [31:0] addr,
			input status_t st, input logic [31:0] ba, input logic [8:0] nf, input logic [8:0] nu);
		dir_row_t r;
		r = row_req(op, addr);
		r.kind = ROW_KNOWN;
		r.want = '{st, ba, nf, nu};
		return r;
	endfunction

	function automatic dir_row_t row_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		dir_row_t r;
		r = '0;
		r.kind    = ROW_CFG;
		r.reg_idx = idx;
		r.value   = val;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endfunction

	// Write one register once the block has gone idle.
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		s_tvalid <= 1'b0;
		while (reply_q.size() != 0 || !s_tready)
			@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_POOL_BASE:  cfg_base = val;
			CFG_BLOCK_SIZE: cfg_size = val[16:0];
			CFG_BLOCK_COUNT: begin
				cfg_count = val[8:0];
				pool_clear();
			end
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic send_request(input logic op, input logic [31:0] addr, input logic typed,
			input pool_reply_t want);
		pool_reply_t guess;
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= addr;
		do
			@(posedge clk);
		while (!s_tready);
		guess = predict_pool_reply(op, addr);
		reply_q.push_back(typed ? want : guess);
		n_sent++;
	endtask

	task automatic pick_setting();
		logic [31:0] base, size, count;
		case ($urandom_range(4))
			0: base = 32'd0;
			1: base = 32'hFFFF_FFFF - $urandom_range(65535);
			2: base = $urandom;
			default: base = $urandom_range(1, 1 << 20);
		endcase
		case ($urandom_range(5))
			0: size = 32'd0;
			1: size = 32'h1FFFF;
			2: size = 32'd1 << $urandom_range(16);
			default: size = $urandom_range(1, 300);
		endcase
		// mostly small pools so that empty and reuse show up often
		case ($urandom_range(5))
			0: count = 32'd0;
			1: count = 32'd256;
			2: count = $urandom_range(257, 511);
			default: count = $urandom_range(1, 12);
		endcase
		cfg_write(CFG_POOL_BASE, base);
		cfg_write(CFG_BLOCK_SIZE, size);
		cfg_write(CFG_BLOCK_COUNT, count);
		n_settings++;
	endtask

	// Mostly allocations and frees of live blocks; the rest are bad addresses.
	task automatic send_random();
		int unsigned pick, sz;
		int          live;
		logic        op;
		logic [31:0] addr;
		pick = $urandom_range(99);
		sz   = pool_size();
		live = -1;
		op   = OP_ALLOC;
		addr = $urandom;
		if (pick >= 45) begin
			op = OP_FREE;
			for (int k = 0, s = $urandom_range(pool_blocks() - 1); k < pool_blocks(); k++)
				if (live < 0 && mdl_busy[(s + k) % pool_blocks()])
					live = (s + k) % pool_blocks();
			if (pick < 80 && live >= 0) begin
				addr = block_addr_of(live);
			end else begin
				case ($urandom_range(5))
					0: addr = 32'd0;
					1: addr = $urandom;
					2: addr = cfg_base - 32'd1;
					3: addr = block_addr_of(pool_blocks());
					4: addr = (live >= 0 ? block_addr_of(live) : cfg_base)
						+ (sz > 1 ? $urandom_range(1, sz - 1) : 0);
					default: addr = block_addr_of($urandom_range(pool_blocks() - 1));
				endcase
			end
		end
		send_request(op, addr, 1'b0, '0);
	endtask

	task automatic run_phase(input int n_items, input int idle, input int stall, input bit hold);
		pick_setting();
		idle_pct  = idle;
		stall_pct = stall;
		if (hold)
			hold_reqs++;
		repeat (n_items)
			send_random();
	endtask

	// Receiver: random stalls, plus a long hold-off on request.
	always @(posedge clk) begin
		if (hold_seen != hold_reqs) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		pool_reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (m_tdata[2:0] <= 3'd5)
				seen_status[m_tdata[2:0]]++;
			if (reply_q.size() == 0) begin
				$error("reply transfer with no request outstanding: 0x%0h", m_tdata);
				errors++;
			end else begin
				want = reply_q.pop_front();
				check_field("status", 32'(want.status), 32'(m_tdata[2:0]));
				check_field("block_address", want.block_addr, m_tdata[34:3]);
				check_field("free_blocks", 32'(want.free_cnt), 32'(m_tdata[43:35]));
				check_field("used_blocks", 32'(want.used_cnt), 32'(m_tdata[52:44]));
			end
		end
	end

	// Watchdog: end the run after too long with no transfer on either side.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		cfg_base  = 32'd4096;
		cfg_size  = 17'd64;
		cfg_count = 9'd256;
		pool_clear();

		// reset pool: base 4096, 64-byte blocks, 256 of them
		dir_tab.push_back(row_known(OP_FREE, 32'd0, ST_NULL, 32'd0, 9'd256, 9'd0));
		dir_tab.push_back(row_known(OP_FREE, 32'd4095, ST_RANGE, 32'd0, 9'd256, 9'd0));
		dir_tab.push_back(row_known(OP_FREE, 32'd20480, ST_RANGE, 32'd0, 9'd256, 9'd0));
		dir_tab.push_back(row_known(OP_FREE, 32'hFFFF_FFFF, ST_RANGE, 32'd0, 9'd256, 9'd0));
		dir_tab.push_back(row_known(OP_FREE, 32'd4097, ST_MISALIGN, 32'd0, 9'd256, 9'd0));
		dir_tab.push_back(row_known(OP_FREE, 32'd4096, ST_NOT_USED, 32'd0, 9'd256, 9'd0));
		dir_tab.push_back(row_known(OP_ALLOC, 32'd0, ST_OK, 32'd20416, 9'd255, 9'd1));
		dir_tab.push_back(row_known(OP_FREE, 32'd20416, ST_OK, 32'd0, 9'd256, 9'd0));
		dir_tab.push_back(row_known(OP_FREE, 32'd20416, ST_NOT_USED, 32'd0, 9'd256, 9'd0));
		dir_tab.push_back(row_req(OP_ALLOC, 32'hFFFF_FFFF));
		dir_tab.push_back(row_req(OP_ALLOC, 32'd0));
		dir_tab.push_back(row_req(OP_FREE, 32'd20352));
		// one-block pool: second allocate finds it empty
		dir_tab.push_back(row_cfg(CFG_BLOCK_COUNT, 32'd1));
		dir_tab.push_back(row_known(OP_ALLOC, 32'd0, ST_OK, 32'd4096, 9'd0, 9'd1));
		dir_tab.push_back(row_known(OP_ALLOC, 32'd0, ST_EMPTY, 32'd0, 9'd0, 9'd1));
		dir_tab.push_back(row_known(OP_FREE, 32'd4096, ST_OK, 32'd0, 9'd1, 9'd0));
		// zero base: block 0 sits at address zero, which cannot be freed
		dir_tab.push_back(row_cfg(CFG_POOL_BASE, 32'd0));
		dir_tab.push_back(row_known(OP_ALLOC, 32'd0, ST_OK, 32'd0, 9'd0, 9'd1));
		dir_tab.push_back(row_known(OP_FREE, 32'd0, ST_NULL, 32'd0, 9'd0, 9'd1));
		// zero size and zero count both act as one
		dir_tab.push_back(row_cfg(CFG_BLOCK_SIZE, 32'd0));
		dir_tab.push_back(row_cfg(CFG_BLOCK_COUNT, 32'd0));
		dir_tab.push_back(row_known(OP_ALLOC, 32'd0, ST_OK, 32'd0, 9'd0, 9'd1));
		dir_tab.push_back(row_known(OP_FREE, 32'd1, ST_RANGE, 32'd0, 9'd0, 9'd1));
		// top base, widest size, count saturated: addresses wrap, range check does not
		dir_tab.push_back(row_cfg(CFG_POOL_BASE, 32'hFFFF_FFFF));
		dir_tab.push_back(row_cfg(CFG_BLOCK_SIZE, 32'h1FFFF));
		dir_tab.push_back(row_cfg(CFG_BLOCK_COUNT, 32'd511));
		dir_tab.push_back(row_req(OP_ALLOC, 32'd0));
		dir_tab.push_back(row_req(OP_ALLOC, 32'd0));
		dir_tab.push_back(row_req(OP_FREE, 32'hFFFF_FFFF));
		dir_tab.push_back(row_req(OP_FREE, 32'hFFFF_FFFF + 32'd33423105));
		// change base and size without re-initializing, then re-initialize
		dir_tab.push_back(row_cfg(CFG_POOL_BASE, 32'd1));
		dir_tab.push_back(row_cfg(CFG_BLOCK_SIZE, 32'd65536));
		dir_tab.push_back(row_req(OP_FREE, 32'd1 + 32'd254 * 32'd65536));
		dir_tab.push_back(row_cfg(CFG_BLOCK_COUNT, 32'd256));
		dir_tab.push_back(row_req(OP_ALLOC, 32'd0));
		dir_tab.push_back(row_req(OP_FREE, 32'h00FF_0001));
		dir_tab.push_back(row_req(OP_FREE, 32'h0003_0006));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == ROW_CFG)
				cfg_write(dir_tab[i].reg_idx, dir_tab[i].value);
			else
				send_request(dir_tab[i].op, dir_tab[i].value, dir_tab[i].kind == ROW_KNOWN,
					dir_tab[i].want);
		end

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: run_phase(100, 0, 0, 1'b0);
				1: run_phase(100, 68, 0, 1'b0);
				2: run_phase(100, 0, 68, 1'b0);
				default: run_phase(100, 21, 21, 1'b0);
			endcase
		end
		// back-pressure: receiver holds off while requests keep coming
		run_phase(50, 0, 0, 1'b1);
		s_tvalid <= 1'b0;

		while (reply_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d requests over %0d random pool settings plus the directed table.",
			n_sent, n_settings);
		$display("Replies: ok %0d, empty %0d, null %0d, range %0d, misaligned %0d, not in use %0d",
			seen_status[0], seen_status[1], seen_status[2], seen_status[3], seen_status[4],
			seen_status[5]);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+sv
sv/fbpa_pkg.sv
sv/fbpa_div.sv
sv/fbpa_dp.sv
sv/fbpa_ctrl.sv
sv/fixed_block_pool_allocator_unit.sv
test/tb.sv
